@@ rtl/tle_pkg.sv @@
package tle_pkg;

    // Default line RAM depth in bytes; an edit line holds one byte fewer
    localparam int LINE_MAX_DEF = 128;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 7;
    localparam int KIND_W  = 2;
    localparam int LEN_W   = 7;
    localparam int POS_W   = 5;
    localparam int ERR_N   = 24;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [POS_W-1:0]  t_pos;

    // Request operations
    typedef enum logic [OP_W-1:0] {
        OP_BYTE    = 2'd0,
        OP_READ    = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ECHO   = 2'd0,
        KIND_READ   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    // Result runs that one request can produce
    typedef enum logic [2:0] {
        MSG_STATUS,
        MSG_READ,
        MSG_CHAR,
        MSG_ERASE,
        MSG_NEWLINE,
        MSG_ERROR
    } t_msg;

    // Character codes
    localparam t_byte CH_BS  = 8'h08;
    localparam t_byte CH_LF  = 8'h0A;
    localparam t_byte CH_CR  = 8'h0D;
    localparam t_byte CH_ESC = 8'h1B;
    localparam t_byte CH_SP  = 8'h20;
    localparam t_byte CH_GT  = 8'h3E;
    localparam t_byte CH_DEL = 8'h7F;

    // Overflow message followed by the prompt
    localparam t_byte ERR_TEXT [ERR_N] = '{
        8'h0D, 8'h0A, 8'h45, 8'h52, 8'h52, 8'h3A, 8'h20, 8'h6C,
        8'h69, 8'h6E, 8'h65, 8'h20, 8'h74, 8'h6F, 8'h6F, 8'h20,
        8'h6C, 8'h6F, 8'h6E, 8'h67, 8'h0D, 8'h0A, 8'h3E, 8'h20
    };

    // Position of the final byte of a run
    function automatic t_pos msg_last(t_msg m);
        t_pos p;
        case (m)
            MSG_ERASE:   p = t_pos'(2);
            MSG_NEWLINE: p = t_pos'(3);
            MSG_ERROR:   p = t_pos'(ERR_N - 1);
            default:     p = '0;
        endcase
        return p;
    endfunction

    // Echo byte at a position of a run
    function automatic t_byte msg_byte(t_msg m, t_pos pos, t_byte ch);
        t_byte b;
        case (m)
            MSG_CHAR:  b = ch;
            MSG_ERASE: b = (pos == t_pos'(1)) ? CH_SP : CH_BS;
            MSG_NEWLINE: begin
                case (pos)
                    t_pos'(0): b = CH_CR;
                    t_pos'(1): b = CH_LF;
                    t_pos'(2): b = CH_GT;
                    default:   b = CH_SP;
                endcase
            end
            MSG_ERROR: b = (pos < t_pos'(ERR_N)) ? ERR_TEXT[pos] : '0;
            default:   b = '0;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/tle_if.sv @@
interface tle_in_if
    import tle_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [BYTE_W-1:0]    in_byte;
    logic [INDEX_W-1:0]   index;

    modport source (output valid, op, in_byte, index, input ready);
    modport sink   (input valid, op, in_byte, index, output ready);
endinterface

interface tle_out_if
    import tle_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    out_byte;
    logic [KIND_W-1:0]    kind;
    logic                 last_of_run;
    logic                 line_ready;
    logic [LEN_W-1:0]     line_length;

    modport source (output valid, out_byte, kind, last_of_run, line_ready, line_length,
                    input ready);
    modport sink   (input valid, out_byte, kind, last_of_run, line_ready, line_length,
                    output ready);
endinterface

@@ rtl/terminal_line_editor.sv @@
// Console line editor.
// Requests arrive on i_req (valid/ready): op selects a received byte, a read
// of one byte of the completed line at index, or a release of that line.
// Results leave on o_rsp (valid/ready), one byte per cycle unless stalled,
// with kind, last_of_run and line_ready / line_length status after the request.
// A received byte yields one result (echoed char or status), three (erase),
// four (CR LF prompt) or twenty-four (overflow message and prompt); every
// other request yields one result.
// The first result of a request is valid in the cycle after it is accepted.
// Throughput: one request per cycle while each yields one result and the
// receiver takes it; a request with more results holds the result stage until
// its last one leaves, and the next request is taken in that same cycle.
// The edit line and the completed line live in two line RAMs that swap roles
// when a line is finished, so no copy is ever made.
// Reset clears the line lengths, the ready flag and the result stage; RAM
// contents are left as they are. When the receiver stalls, the current
// result holds and i_req.ready drops until its last byte is taken.
module terminal_line_editor
    import tle_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tle_in_if.sink     i_req,
    tle_out_if.source  o_rsp
);
    localparam int AW = $clog2(LINE_MAX);
    localparam int CW = (AW > INDEX_W) ? AW : INDEX_W;
    localparam logic [AW-1:0] LEN_FULL = AW'(LINE_MAX - 1);

    // Editor state
    logic [AW-1:0] r_edit_len, n_edit_len;
    logic [AW-1:0] r_done_len, n_done_len;
    logic          r_ready, n_ready;
    logic          r_sel, n_sel;

    // Result stage
    logic             r_busy;
    t_msg             r_msg, n_msg;
    t_pos             r_pos;
    t_byte            r_ch;
    logic             r_hit, n_hit;
    logic             r_rd_bank;
    logic             r_stat_ready;
    logic [LEN_W-1:0] r_stat_len;

    logic  accept;
    logic  at_last;
    logic  wr_en;
    t_byte rd_data [2];

    assign accept      = i_req.valid && i_req.ready;
    assign at_last     = (r_pos == msg_last(r_msg));
    assign i_req.ready = !r_busy || (o_rsp.ready && at_last);

    // Decode the request and update the editor state
    always_comb begin
        n_edit_len = r_edit_len;
        n_done_len = r_done_len;
        n_ready    = r_ready;
        n_sel      = r_sel;
        n_msg      = MSG_STATUS;
        n_hit      = 1'b0;
        wr_en      = 1'b0;
        if (accept) begin
            unique case (i_req.op)
                OP_BYTE: begin
                    if (i_req.in_byte == CH_ESC) begin
                        n_edit_len = '0;
                    end else if (i_req.in_byte == CH_BS || i_req.in_byte == CH_DEL) begin
                        if (r_edit_len != '0) begin
                            n_edit_len = r_edit_len - AW'(1);
                            n_msg      = MSG_ERASE;
                        end
                    end else if (i_req.in_byte == CH_CR || i_req.in_byte == CH_LF) begin
                        n_msg = MSG_NEWLINE;
                        if (r_edit_len != '0) begin
                            n_done_len = r_edit_len;
                            n_ready    = 1'b1;
                            n_sel      = ~r_sel;
                            n_edit_len = '0;
                        end
                    end else if (i_req.in_byte < CH_SP) begin
                        n_msg = MSG_STATUS;
                    end else if (r_edit_len < LEN_FULL) begin
                        wr_en      = 1'b1;
                        n_edit_len = r_edit_len + AW'(1);
                        n_msg      = MSG_CHAR;
                    end else begin
                        n_edit_len = '0;
                        n_msg      = MSG_ERROR;
                    end
                end
                OP_READ: begin
                    n_msg = MSG_READ;
                    n_hit = CW'(i_req.index) < CW'(r_done_len);
                end
                OP_RELEASE: begin
                    n_ready = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Line RAMs: the edit line is the bank not selected as completed line
    for (genvar b = 0; b < 2; b++) begin : g_bank
        tle_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (LINE_MAX)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en && (r_sel != 1'(b))),
            .i_wr_addr (r_edit_len),
            .i_wr_data (i_req.in_byte),
            .i_rd_en   (accept),
            .i_rd_addr (AW'(i_req.index)),
            .o_rd_data (rd_data[b])
        );
    end

    // Hold editor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edit_len <= '0;
            r_done_len <= '0;
            r_ready    <= 1'b0;
            r_sel      <= 1'b0;
        end else begin
            r_edit_len <= n_edit_len;
            r_done_len <= n_done_len;
            r_ready    <= n_ready;
            r_sel      <= n_sel;
        end
    end

    // Load a new run on accept, advance through it as bytes are taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_pos  <= '0;
        end else if (o_rsp.valid && o_rsp.ready) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_pos <= r_pos + t_pos'(1);
            end
        end
    end

    // Capture the run payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_msg        <= n_msg;
            r_ch         <= i_req.in_byte;
            r_hit        <= n_hit;
            r_rd_bank    <= r_sel;
            r_stat_ready <= n_ready;
            r_stat_len   <= LEN_W'(n_done_len);
        end
    end

    // Drive the result
    always_comb begin
        case (r_msg)
            MSG_READ: begin
                o_rsp.out_byte = r_hit ? rd_data[r_rd_bank] : '0;
                o_rsp.kind     = KIND_READ;
            end
            MSG_STATUS: begin
                o_rsp.out_byte = '0;
                o_rsp.kind     = KIND_STATUS;
            end
            default: begin
                o_rsp.out_byte = msg_byte(r_msg, r_pos, r_ch);
                o_rsp.kind     = KIND_ECHO;
            end
        endcase
    end

    assign o_rsp.valid       = r_busy;
    assign o_rsp.last_of_run = at_last;
    assign o_rsp.line_ready  = r_stat_ready;
    assign o_rsp.line_length = r_stat_len;

endmodule

@@ rtl/tle_ram.sv @@
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import tle_pkg::*;

    localparam int EDIT_CAP     = LINE_MAX_DEF - 1;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 150;
    localparam string OVERFLOW_TEXT = "\015\012ERR: line too long\015\012> ";

    typedef logic [INDEX_W-1:0] t_index;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [KIND_W-1:0] kind;
        logic              last_of_run;
        logic              line_ready;
        logic [LEN_W-1:0]  line_length;
    } t_reply;

    // Mirror of the editor state plus the replies still owed by the block
    class console_mirror;
        t_byte  edit_buf [LINE_MAX_DEF];
        t_byte  done_buf [LINE_MAX_DEF];
        int     edit_len = 0;
        int     done_len = 0;
        bit     line_flag = 1'b0;
        t_reply owed_replies [$];
        int     errors = 0;

        function void add_reply(t_byte b, logic [KIND_W-1:0] k, logic last);
            t_reply r;
            r.out_byte    = b;
            r.kind        = k;
            r.last_of_run = last;
            r.line_ready  = line_flag;
            r.line_length = LEN_W'(done_len);
            owed_replies.push_back(r);
        endfunction

        // Update the state for one accepted request and queue its replies
        function void take_request(t_op op, t_byte b, t_index idx);
            t_byte echo [$];
            t_byte data;
            int    i;
            data = '0;
            case (op)
                OP_BYTE: begin
                    if (b == CH_ESC) begin
                        edit_len = 0;
                    end else if (b == CH_BS || b == CH_DEL) begin
                        if (edit_len > 0) begin
                            edit_len--;
                            echo.push_back(CH_BS);
                            echo.push_back(CH_SP);
                            echo.push_back(CH_BS);
                        end
                    end else if (b == CH_CR || b == CH_LF) begin
                        echo.push_back(CH_CR);
                        echo.push_back(CH_LF);
                        if (edit_len > 0) begin
                            for (i = 0; i < edit_len; i++) done_buf[i] = edit_buf[i];
                            done_len  = edit_len;
                            line_flag = 1'b1;
                            edit_len  = 0;
                        end
                        echo.push_back(CH_GT);
                        echo.push_back(CH_SP);
                    end else if (b < CH_SP) begin
                        // drop other control bytes
                    end else if (edit_len < EDIT_CAP) begin
                        edit_buf[edit_len] = b;
                        edit_len++;
                        echo.push_back(b);
                    end else begin
                        // full line: clear it and report
                        edit_len = 0;
                        for (i = 0; i < OVERFLOW_TEXT.len(); i++)
                            echo.push_back(t_byte'(OVERFLOW_TEXT[i]));
                    end
                end
                OP_READ: begin
                    if (int'(idx) < done_len) data = done_buf[idx];
                    add_reply(data, KIND_READ, 1'b1);
                    return;
                end
                OP_RELEASE: begin
                    line_flag = 1'b0;
                end
                default: begin
                end
            endcase
            if (echo.size() == 0) begin
                add_reply('0, KIND_STATUS, 1'b1);
            end else begin
                for (i = 0; i < echo.size(); i++)
                    add_reply(echo[i], KIND_ECHO, i == echo.size() - 1);
            end
        endfunction

        // Compare one taken reply with the oldest owed one
        function void check_reply(t_reply seen);
            t_reply want;
            if (owed_replies.size() == 0) begin
                $error("unrequested reply: out_byte %0h kind %0d", seen.out_byte, seen.kind);
                errors++;
                return;
            end
            want = owed_replies.pop_front();
            if (seen.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, actual %0h", want.out_byte, seen.out_byte);
                errors++;
            end
            if (seen.kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, seen.kind);
                errors++;
            end
            if (seen.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0d, actual %0d",
                       want.last_of_run, seen.last_of_run);
                errors++;
            end
            if (seen.line_ready !== want.line_ready) begin
                $error("line_ready: expected %0d, actual %0d", want.line_ready, seen.line_ready);
                errors++;
            end
            if (seen.line_length !== want.line_length) begin
                $error("line_length: expected %0d, actual %0d",
                       want.line_length, seen.line_length);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   burst_left = 0;
    int   counted_requests = 0;
    int   cycle_count = 0;
    int   stall_tick = 0;
    int   stall_mode = 0;

    console_mirror mirror = new();

    tle_in_if  req ();
    tle_out_if rsp ();

    terminal_line_editor dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Random glyph: mostly ASCII printable, some high bytes
    function automatic t_byte random_glyph();
        if ($urandom_range(0, 99) < 85) return t_byte'($urandom_range(32, 126));
        return t_byte'($urandom_range(128, 255));
    endfunction

    // Issue one request in bursts with random gaps, wait for its handshake
    task automatic send_request(t_op op, t_byte b, t_index idx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        req.valid   <= 1'b1;
        req.op      <= op;
        req.in_byte <= b;
        req.index   <= idx;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        mirror.take_request(op, b, idx);
        if (!(op == OP_BYTE && b < CH_SP && b != CH_BS && b != CH_CR && b != CH_LF
              && b != CH_ESC))
            counted_requests++;
    endtask

    task automatic type_glyphs(int n);
        int i;
        for (i = 0; i < n; i++) send_request(OP_BYTE, random_glyph(), '0);
    endtask

    task automatic run_directed();
        // empty store, empty line
        send_request(OP_READ, '0, '0);
        send_request(OP_RELEASE, '0, '0);
        send_request(OP_BYTE, CH_BS, '0);
        send_request(OP_BYTE, CH_DEL, '0);
        send_request(OP_BYTE, CH_ESC, '0);
        send_request(OP_BYTE, 8'h00, '0);
        send_request(OP_BYTE, 8'h1F, '0);
        send_request(OP_BYTE, CH_CR, '0);
        send_request(OP_BYTE, CH_LF, '0);
        // printable extremes, erase both ways, clear with escape
        send_request(OP_BYTE, CH_SP, '0);
        send_request(OP_BYTE, 8'h7E, '0);
        send_request(OP_BYTE, 8'h80, '0);
        send_request(OP_BYTE, 8'hFF, '0);
        send_request(OP_BYTE, CH_DEL, '0);
        send_request(OP_BYTE, CH_BS, '0);
        send_request(OP_BYTE, CH_ESC, '0);
        // finish a short line and read it back, past the end too
        send_request(OP_BYTE, 8'h41, '0);
        send_request(OP_BYTE, 8'h42, '0);
        send_request(OP_BYTE, CH_LF, '0);
        send_request(OP_READ, '0, 7'd0);
        send_request(OP_READ, '0, 7'd1);
        send_request(OP_READ, '0, 7'd2);
        send_request(OP_READ, '0, 7'd127);
        // overwrite an unreleased line, then read after release
        send_request(OP_BYTE, 8'h5A, '0);
        send_request(OP_BYTE, CH_CR, '0);
        send_request(OP_RELEASE, '0, '0);
        send_request(OP_READ, '0, 7'd0);
        // longest line that fits
        type_glyphs(EDIT_CAP);
        send_request(OP_BYTE, CH_CR, '0);
        send_request(OP_READ, '0, 7'd126);
        send_request(OP_READ, '0, 7'd127);
        send_request(OP_RELEASE, '0, '0);
        // one byte too many on a full line
        type_glyphs(EDIT_CAP + 1);
        send_request(OP_BYTE, CH_BS, '0);
    endtask

    task automatic run_random();
        int pick;
        int len;
        int i;
        counted_requests = 0;
        while (counted_requests < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                // well-formed line with random content and edits
                if ($urandom_range(0, 39) == 0) begin
                    len = EDIT_CAP + $urandom_range(0, 1);
                    type_glyphs(len);
                end else begin
                    len = $urandom_range(1, 12);
                    for (i = 0; i < len; i++) begin
                        send_request(OP_BYTE, random_glyph(), '0);
                        if ($urandom_range(0, 9) == 0)
                            send_request(OP_BYTE, $urandom_range(0, 1) ? CH_BS : CH_DEL, '0);
                    end
                end
                if ($urandom_range(0, 19) == 0) send_request(OP_BYTE, CH_ESC, '0);
                send_request(OP_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF, '0);
                repeat ($urandom_range(1, 4))
                    send_request(OP_READ, '0, t_index'($urandom_range(0, len + 2)));
                if ($urandom_range(0, 9) < 7) send_request(OP_RELEASE, '0, '0);
            end else if (pick < 80) begin
                // noise request
                send_request(t_op'($urandom_range(0, 2)), t_byte'($urandom_range(0, 255)),
                             t_index'($urandom_range(0, 127)));
            end else if (pick < 90) begin
                // broken line: interrupted by a control byte
                type_glyphs($urandom_range(0, 5));
                send_request(OP_BYTE, t_byte'($urandom_range(0, 31)), '0);
                type_glyphs($urandom_range(0, 2));
            end else begin
                // erase past the start of the line
                len = $urandom_range(0, 4);
                type_glyphs(len);
                repeat (len + $urandom_range(1, 3))
                    send_request(OP_BYTE, $urandom_range(0, 1) ? CH_BS : CH_DEL, '0);
            end
        end
    endtask

    // Stimulus, drain and verdict
    initial begin
        req.valid   <= 1'b0;
        req.op      <= OP_BYTE;
        req.in_byte <= '0;
        req.index   <= '0;
        rst_n       <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        req.valid <= 1'b0;
        while (mirror.owed_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Take replies and stall on a changing pattern
    initial begin
        t_reply seen;
        rsp.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready) begin
                seen.out_byte    = rsp.out_byte;
                seen.kind        = rsp.kind;
                seen.last_of_run = rsp.last_of_run;
                seen.line_ready  = rsp.line_ready;
                seen.line_length = rsp.line_length;
                mirror.check_reply(seen);
            end
            stall_tick++;
            if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       rsp.ready <= 1'b1;
                1:       rsp.ready <= ($urandom_range(0, 1) == 1);
                2:       rsp.ready <= (stall_tick % 4 != 3);
                default: rsp.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Hold a hard limit on run length
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tle_pkg.sv
rtl/tle_if.sv
rtl/tle_ram.sv
rtl/terminal_line_editor.sv
bench/tb.sv
